// File: hdl/urcv_pkg.sv
// Shared types, constants and a checksum helper for the UDP receive checksum validator.
package urcv_pkg;

    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [15:0] HDR_BYTES  = 16'd8;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [15:0] SUM_GOOD   = 16'hFFFF;
    localparam logic [18:0] PROTO_UDP  = 19'd17;

    localparam logic [15:0] IDX_FIRST    = 16'd0;
    localparam logic [15:0] IDX_SRC_PORT = 16'd1;
    localparam logic [15:0] IDX_DST_PORT = 16'd3;
    localparam logic [15:0] IDX_LENGTH   = 16'd5;
    localparam logic [15:0] IDX_CHECKSUM = 16'd7;

    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_SHORT     = 2'd1;
    localparam logic [1:0] VERDICT_BAD_LEN   = 2'd2;
    localparam logic [1:0] VERDICT_BAD_CSUM  = 2'd3;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] payload_length;
        logic [15:0] dst_port;
        logic [15:0] source_port;
    } t_result;

    // fold a wide integer sum to a 16-bit one's-complement sum
    function automatic logic [15:0] fold19(input logic [18:0] v);
        logic [16:0] t;
        t = {1'b0, v[15:0]} + {14'b0, v[18:16]};
        return t[15:0] + {15'b0, t[16]};
    endfunction

endpackage

// File: hdl/urcv_hdr_sum.sv
// Header capture, running checksum state and verdict logic, one byte per step.
module urcv_hdr_sum
    import urcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic [18:0] i_pseudo,
    input  logic        i_last,
    output t_result     o_result
);

    logic [15:0] r_count,   n_count;
    logic [15:0] r_sum,     n_sum;
    logic [15:0] r_sum_odd, n_sum_odd;
    logic [7:0]  r_pend,    n_pend;
    logic [15:0] r_sport,   n_sport;
    logic [15:0] r_dport,   n_dport;
    logic [15:0] r_len,     n_len;
    logic        r_csum_on, n_csum_on;

    logic        in_range;
    logic [18:0] cur_sum;
    logic [15:0] word;
    logic [18:0] odd_add;
    logic [15:0] sum_final;

    always_comb begin
        in_range  = (r_count < HDR_BYTES) || (r_count < r_len);
        cur_sum   = (r_count == IDX_FIRST) ? i_pseudo : {3'b0, r_sum};
        word      = {r_pend, i_data_byte};
        odd_add   = {3'b0, r_sum} + {3'b0, word}
                  + ((r_count == IDX_LENGTH) ? {3'b0, word} : 19'd0);

        n_count   = (r_count == COUNT_MAX) ? r_count : r_count + 16'd1;
        n_sum     = (r_count == IDX_FIRST) ? fold19(i_pseudo) : r_sum;
        n_sum_odd = r_sum_odd;
        n_pend    = r_pend;
        n_sport   = r_sport;
        n_dport   = r_dport;
        n_len     = r_len;
        n_csum_on = r_csum_on;

        if (in_range) begin
            if (!r_count[0]) begin
                n_pend    = i_data_byte;
                n_sum_odd = fold19(cur_sum + {3'b0, i_data_byte, 8'b0});
            end else begin
                n_sum = fold19(odd_add);
                case (r_count)
                    IDX_SRC_PORT: n_sport   = word;
                    IDX_DST_PORT: n_dport   = word;
                    IDX_LENGTH:   n_len     = word;
                    IDX_CHECKSUM: n_csum_on = (word != 16'd0);
                    default:      n_csum_on = n_csum_on;
                endcase
            end
        end

        sum_final = n_len[0] ? n_sum_odd : n_sum;

        o_result.source_port    = n_sport;
        o_result.dst_port       = n_dport;
        o_result.payload_length = 16'd0;
        if (n_count < HDR_BYTES) begin
            o_result.verdict     = VERDICT_SHORT;
            o_result.source_port = 16'd0;
            o_result.dst_port    = 16'd0;
        end else if ((n_len < HDR_BYTES) || (n_len > n_count)) begin
            o_result.verdict = VERDICT_BAD_LEN;
        end else begin
            o_result.payload_length = n_len - HDR_BYTES;
            o_result.verdict = (n_csum_on && (sum_final != SUM_GOOD)) ?
                               VERDICT_BAD_CSUM : VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_sum_odd <= '0;
            r_pend    <= '0;
            r_sport   <= '0;
            r_dport   <= '0;
            r_len     <= '0;
            r_csum_on <= 1'b0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_sum_odd <= n_sum_odd;
            r_pend    <= n_pend;
            r_sport   <= n_sport;
            r_dport   <= n_dport;
            r_len     <= n_len;
            r_csum_on <= n_csum_on;
        end
    end

endmodule

// File: hdl/udp_receive_checksum_validator.sv
// Top level of the UDP receive header and checksum validator.
//
//  channel  direction  carries                                   tlast      tuser
//  s_axis   in         one datagram byte plus IPv4 addresses     last_byte  -
//  m_axis   out        one verdict per datagram                  -          verdict
//
// One byte per cycle sustained, except while a last byte waits behind a stalled result; a
// byte enters the input register at its transfer and is folded into the header/checksum state
// as it leaves that register, at the same edge that registers a last byte's verdict.
// Reset (i_rst_n low, synchronous) clears all datagram state and both valid flags.
// A stalled result holds in the output register; only a last byte waits behind it in
// the input register, other bytes keep flowing.
module udp_receive_checksum_validator
    import urcv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // data_byte, src_addr, dst_addr
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // source_port, dst_port, payload_length
    output logic [1:0]            m_axis_tuser    // verdict
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [18:0] r_in_pseudo;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;

    logic        advance;
    logic        step;
    logic        in_xfer;
    logic [18:0] n_pseudo;
    t_result     result;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (advance || !r_in_last);
    assign s_axis_tready = !r_in_valid || step;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign n_pseudo = {3'b0, s_axis_tdata[39:24]} + {3'b0, s_axis_tdata[23:8]}
                    + {3'b0, s_axis_tdata[71:56]} + {3'b0, s_axis_tdata[55:40]}
                    + PROTO_UDP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte   <= s_axis_tdata[7:0];
            r_in_pseudo <= n_pseudo;
            r_in_last   <= s_axis_tlast;
        end
    end

    urcv_hdr_sum u_hdr_sum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_pseudo    (r_in_pseudo),
        .i_last      (r_in_last),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.payload_length, r_out.dst_port, r_out.source_port};
    assign m_axis_tuser  = r_out.verdict;

endmodule

// File: hdl/urcv_checker.sv
// Port-level checks for the UDP receive checksum validator, bound to the top level.
module urcv_checker
    import urcv_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == VERDICT_SHORT) |-> m_axis_tdata == '0)
        else $error("short datagram reports nonzero fields");

    a_badlen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == VERDICT_BAD_LEN) |-> m_axis_tdata[47:32] == 16'd0)
        else $error("bad length reports nonzero payload length");

    a_plen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:32] <= (COUNT_MAX - HDR_BYTES))
        else $error("payload length out of range");

endmodule

bind udp_receive_checksum_validator urcv_checker u_urcv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
